// ===== sv/rks_pkg.sv =====
`default_nettype none
package rks_pkg;
  localparam int MaxFramesDefault = 64;
  localparam int KeyW = 128;

  typedef struct packed {
    logic [15:0] depth_layer;
    logic [31:0] sort_y_bits;
    logic signed [31:0] draw_rank;
    logic [31:0] pos_x_bits;
    logic [15:0] record_id;
    logic        last_frame;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] frame_index;
    logic        last_result;
    logic        overflowed;
  } out_beat_t;

  function automatic logic [31:0] float_code(input logic [31:0] b);
    float_code = b[31] ? ~b : (b ^ 32'h8000_0000);
  endfunction

  function automatic logic [KeyW-1:0] build_key(input in_beat_t d);
    logic [31:0] dc;
    dc = d.draw_rank ^ 32'h8000_0000;
    build_key = {d.depth_layer, ~float_code(d.sort_y_bits), dc, float_code(d.pos_x_bits),
                 d.record_id};
  endfunction
endpackage
`default_nettype wire

// ===== sv/rks_ram.sv =====
`default_nettype none
module rks_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/rks_datapath.sv =====
`default_nettype none
// Insertion sort in one RAM: shifts larger keys up a slot by read then write.
module rks_datapath #(
  parameter int MaxFrames = rks_pkg::MaxFramesDefault,
  localparam int AW = $clog2(MaxFrames)
) (
  input  wire logic                  clk,
  input  wire rks_pkg::in_beat_t     in_data,
  input  wire logic                  key_load,
  input  wire logic                  ram_we,
  input  wire logic [AW-1:0]         ram_waddr,
  input  wire logic                  wsel_key,
  input  wire logic [AW-1:0]         ram_raddr,
  output logic                       key_less,
  output logic [15:0]                rd_index
);
  logic [rks_pkg::KeyW-1:0] key;
  logic [rks_pkg::KeyW-1:0] rdata;
  logic [rks_pkg::KeyW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (key_load) key <= rks_pkg::build_key(in_data);
  end

  assign wdata    = wsel_key ? key : rdata;
  assign key_less = key < rdata;
  assign rd_index = rdata[15:0] - 16'd1;

  rks_ram #(.Width(rks_pkg::KeyW), .Depth(MaxFrames)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(wdata),
    .raddr(ram_raddr), .rdata(rdata)
  );
endmodule
`default_nettype wire

// ===== sv/rks_ctrl.sv =====
`default_nettype none
module rks_ctrl #(
  parameter int MaxFrames = rks_pkg::MaxFramesDefault,
  localparam int AW = $clog2(MaxFrames),
  localparam int CW = $clog2(MaxFrames + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_last,
  output logic                   out_ovf,
  output logic                   key_load,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic                   wsel_key,
  output logic [AW-1:0]          ram_raddr,
  input  wire logic              key_less
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CMP   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_WAIT  = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic          ovf;
  logic          last_seen;
  logic [CW-1:0] rd;

  assign in_ready  = state == S_IDLE;
  assign key_load  = in_valid && in_ready;
  assign out_last  = rd == count - CW'(1);
  assign out_ovf   = ovf;
  assign out_valid = state == S_WAIT;

  // S_CMP compares key with entry pos-1 (read issued in S_READ)
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    wsel_key   = 1'b1;
    ram_waddr  = pos[AW-1:0];
    ram_raddr  = AW'(pos - CW'(1));
    case (state)
      S_IDLE: if (key_load) begin
        if (count == CW'(MaxFrames)) begin
          state_next = in_last ? S_EMIT : S_IDLE;
        end else if (count == '0) begin
          // empty store: write straight away
          state_next = S_CMP;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_CMP;
      S_CMP: begin
        if (pos != '0 && key_less) begin
          ram_we     = 1'b1;
          wsel_key   = 1'b0;
          state_next = S_READ;
        end else begin
          ram_we     = count != CW'(MaxFrames);
          state_next = last_seen ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        ram_raddr  = rd[AW-1:0];
        state_next = S_WAIT;
      end
      S_WAIT: begin
        ram_raddr = rd[AW-1:0];
        if (out_ready) state_next = out_last ? S_IDLE : S_EMIT;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; ovf <= 1'b0; pos <= '0; rd <= '0;
      last_seen <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: if (key_load) begin
          pos <= count; last_seen <= in_last;
          if (count == CW'(MaxFrames)) begin
            ovf <= 1'b1;
            rd <= '0;
          end
        end
        S_CMP: begin
          if (pos != '0 && key_less) begin
            pos <= pos - CW'(1);
          end else begin
            count <= count + CW'(1);
            rd <= '0;
          end
        end
        S_WAIT: if (out_ready) begin
          if (out_last) begin
            count <= '0; ovf <= 1'b0;
          end else begin
            rd <= rd + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/render_key_sorter.sv =====
// Channel | dir | payload              | handshake
// in      | in  | rks_pkg::in_beat_t   | in_valid / in_ready
// out     | out | rks_pkg::out_beat_t  | out_valid / out_ready
// Loading: a beat is taken in S_IDLE; each slot shifted costs a RAM read and a
// compare/write; a key into an empty store goes straight to its write, and a beat
// dropped on a full store is taken but not stored. No beat is taken mid-placement.
// Emitting: S_EMIT reads a result (registered RAM read), S_WAIT holds it on stall.
// Reset (rst, synchronous) empties the store at once; stored keys need no clearing.
// Input is not taken while a list is being emitted.
`default_nettype none
module render_key_sorter #(
  parameter int MAX_FRAMES = rks_pkg::MaxFramesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rks_pkg::in_beat_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rks_pkg::out_beat_t      out_data
);
  localparam int AW = $clog2(MAX_FRAMES);
  logic          key_load, ram_we, wsel_key, key_less, o_last, o_ovf;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   rd_index;

  rks_ctrl #(.MaxFrames(MAX_FRAMES)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_last(in_data.last_frame), .out_valid(out_valid), .out_ready(out_ready),
    .out_last(o_last), .out_ovf(o_ovf), .key_load(key_load), .ram_we(ram_we),
    .ram_waddr(waddr), .wsel_key(wsel_key), .ram_raddr(raddr), .key_less(key_less)
  );

  rks_datapath #(.MaxFrames(MAX_FRAMES)) u_dp (
    .clk(clk), .in_data(in_data), .key_load(key_load), .ram_we(ram_we),
    .ram_waddr(waddr), .wsel_key(wsel_key), .ram_raddr(raddr),
    .key_less(key_less), .rd_index(rd_index)
  );

  assign out_data.frame_index = rd_index;
  assign out_data.last_result = o_last;
  assign out_data.overflowed  = o_ovf;
endmodule
`default_nettype wire

// ===== sv/rks_checker.sv =====
`default_nettype none
module rks_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rks_pkg::out_beat_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input beat withdrawn before acceptance");
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("valid after reset");
endmodule
bind render_key_sorter rks_checker u_chk (.*);
`default_nettype wire
